// File: hdl/assert_macros.svh
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: hdl/sacc_pkg.sv
package sacc_pkg;

	localparam int SETS        = 16;
	localparam int WAYS        = 4;
	localparam int ADDR_BITS   = 32;
	localparam int OFFSET_BITS = 3;

	// SETS and WAYS are powers of two
	localparam int SET_BITS  = $clog2(SETS);
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_BITS  = ADDR_BITS - OFFSET_BITS - SET_BITS;
	localparam int LINE_BITS = TAG_BITS + SET_BITS;

	localparam int WAY_OUT_BITS  = 2;
	localparam int WB_LINE_BITS  = 29;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 2;
	localparam int LFSR_BITS     = 16;

	localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'h0001;

	localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WT_MODE = 1'd1;

	localparam logic [1:0] POL_LRU    = 2'd0;
	localparam logic [1:0] POL_FIFO   = 2'd1;
	localparam logic [1:0] POL_RANDOM = 2'd2;

	// Directory state of one set
	typedef struct packed {
		logic [WAYS-1:0][TAG_BITS-1:0] tag;
		logic [WAYS-1:0]               valid;
		logic [WAYS-1:0]               dirty;
		logic [WAYS-1:0][WAY_BITS-1:0] rank;
		logic [WAY_BITS-1:0]           fifo;
	} set_row_t;

	typedef struct packed {
		logic                    hit;
		logic [WAY_OUT_BITS-1:0] way;
		logic                    fill_needed;
		logic                    writeback_needed;
		logic [WB_LINE_BITS-1:0] writeback_line;
		logic                    memory_write;
	} result_t;

	function automatic set_row_t reset_row();
		set_row_t r;
		r = '0;
		for (int k = 0; k < WAYS; k++) begin
			r.rank[k] = WAY_BITS'(k);
		end
		return r;
	endfunction

	// Galois form, shift right
	function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s);
		logic [LFSR_BITS-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

// File: hdl/sacc_lookup.sv
module sacc_lookup (
	input  sacc_pkg::set_row_t                   row,
	input  logic [sacc_pkg::TAG_BITS-1:0]        tag,
	input  logic [sacc_pkg::SET_BITS-1:0]        set_idx,
	input  logic                                 kind,
	input  logic [1:0]                           policy,
	input  logic                                 wt_mode,
	input  logic [sacc_pkg::LFSR_BITS-1:0]       lfsr,
	output sacc_pkg::set_row_t                   new_row,
	output sacc_pkg::result_t                    res,
	output logic                                 lfsr_adv,
	output logic [sacc_pkg::LFSR_BITS-1:0]       lfsr_next
);

	logic                              hit_found;
	logic                              empty_found;
	logic [sacc_pkg::WAY_BITS-1:0]     hit_way;
	logic [sacc_pkg::WAY_BITS-1:0]     empty_way;
	logic [sacc_pkg::WAY_BITS-1:0]     lru_way;
	logic [sacc_pkg::WAY_BITS-1:0]     w;
	logic [sacc_pkg::WAY_BITS-1:0]     r;
	logic                              wb;

	assign lfsr_next = sacc_pkg::lfsr_step(lfsr);

	// per-way match, first empty way, LRU way
	always_comb begin
		hit_found   = 1'b0;
		empty_found = 1'b0;
		hit_way     = '0;
		empty_way   = '0;
		lru_way     = '0;
		for (int k = sacc_pkg::WAYS - 1; k >= 0; k--) begin
			if (row.valid[k] && row.tag[k] == tag) begin
				hit_found = 1'b1;
				hit_way   = sacc_pkg::WAY_BITS'(k);
			end
			if (!row.valid[k]) begin
				empty_found = 1'b1;
				empty_way   = sacc_pkg::WAY_BITS'(k);
			end
			if (row.rank[k] == '0) begin
				lru_way = sacc_pkg::WAY_BITS'(k);
			end
		end
	end

	always_comb begin
		new_row  = row;
		lfsr_adv = 1'b0;
		w        = '0;
		r        = '0;
		if (hit_found) begin
			w = hit_way;
		end else if (empty_found) begin
			w = empty_way;
		end else begin
			case (policy)
				sacc_pkg::POL_LRU: begin
					w = lru_way;
				end
				sacc_pkg::POL_FIFO: begin
					w = row.fifo;
					if (row.fifo == sacc_pkg::WAY_BITS'(sacc_pkg::WAYS - 1)) begin
						new_row.fifo = '0;
					end else begin
						new_row.fifo = row.fifo + sacc_pkg::WAY_BITS'(1);
					end
				end
				default: begin
					lfsr_adv = 1'b1;
					w        = lfsr_next[sacc_pkg::WAY_BITS-1:0];
				end
			endcase
		end

		wb = !hit_found && !empty_found && row.dirty[w];

		if (!hit_found) begin
			new_row.valid[w] = 1'b1;
			new_row.dirty[w] = 1'b0;
			new_row.tag[w]   = tag;
		end

		// make w most recently used
		r = row.rank[w];
		for (int k = 0; k < sacc_pkg::WAYS; k++) begin
			if (row.rank[k] > r) begin
				new_row.rank[k] = row.rank[k] - sacc_pkg::WAY_BITS'(1);
			end
		end
		new_row.rank[w] = sacc_pkg::WAY_BITS'(sacc_pkg::WAYS - 1);

		if (kind && !wt_mode) begin
			new_row.dirty[w] = 1'b1;
		end

		res.hit              = hit_found;
		res.way              = sacc_pkg::WAY_OUT_BITS'(w);
		res.fill_needed      = !hit_found;
		res.writeback_needed = wb;
		res.writeback_line   = wb ? sacc_pkg::WB_LINE_BITS'({row.tag[w], set_idx}) : '0;
		res.memory_write     = kind && wt_mode;
	end

endmodule

// File: hdl/set_associative_cache_controller.sv
// Tag and replacement directory of a 16-set, 4-way cache with 8-byte lines.
// Each accepted item (kind, address) returns one result: hit, way, fill and
// dirty-victim write-back info, and a write-through flag. The sustained rate
// is one item per clock unless out_stall holds the output. All per-set state
// (tags, valid, dirty, LRU ranks, FIFO pointer) lives in one row RAM with a
// single registered read port read at acceptance and written, as the result
// is registered, when the item leaves the lookup stage; a same-set item that
// follows directly takes the updated row through a bypass. Per-set flops mark
// rows never written, which read as the reset state, so no clearing pass is
// needed after reset. Victim policy and write mode must be written through
// the cfg port while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module set_associative_cache_controller (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [sacc_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [sacc_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     kind,
	input  logic [sacc_pkg::ADDR_BITS-1:0]           address,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     hit,
	output logic [sacc_pkg::WAY_OUT_BITS-1:0]        way,
	output logic                                     fill_needed,
	output logic                                     writeback_needed,
	output logic [sacc_pkg::WB_LINE_BITS-1:0]        writeback_line,
	output logic                                     memory_write
);

	logic [1:0]                           policy_q;
	logic                                 wt_mode_q;
	logic [sacc_pkg::LFSR_BITS-1:0]       lfsr_q;
	logic [sacc_pkg::SETS-1:0]            row_init_q;

	logic                                 s1_valid_q;
	logic                                 kind_s1;
	logic [sacc_pkg::SET_BITS-1:0]        set_s1;
	logic [sacc_pkg::TAG_BITS-1:0]        tag_s1;
	logic                                 fwd_s1;
	sacc_pkg::set_row_t                   fwd_row_s1;
	sacc_pkg::set_row_t                   rd_row_s1;

	logic                                 out_valid_q;
	sacc_pkg::result_t                    res_q;

	sacc_pkg::set_row_t                   set_mem [sacc_pkg::SETS];

	logic [sacc_pkg::SET_BITS-1:0]        set_in;
	logic                                 out_free;
	logic                                 s1_move;
	logic                                 in_accept;
	sacc_pkg::set_row_t                   row_s1;
	sacc_pkg::set_row_t                   new_row;
	sacc_pkg::result_t                    res;
	logic                                 lfsr_adv;
	logic [sacc_pkg::LFSR_BITS-1:0]       lfsr_next;

	assign set_in    = address[sacc_pkg::OFFSET_BITS +: sacc_pkg::SET_BITS];
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_move   = s1_valid_q && out_free;
	assign in_stall  = s1_valid_q && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		if (fwd_s1) begin
			row_s1 = fwd_row_s1;
		end else if (row_init_q[set_s1]) begin
			row_s1 = rd_row_s1;
		end else begin
			row_s1 = sacc_pkg::reset_row();
		end
	end

	sacc_lookup u_lookup (
		.row       (row_s1),
		.tag       (tag_s1),
		.set_idx   (set_s1),
		.kind      (kind_s1),
		.policy    (policy_q),
		.wt_mode   (wt_mode_q),
		.lfsr      (lfsr_q),
		.new_row   (new_row),
		.res       (res),
		.lfsr_adv  (lfsr_adv),
		.lfsr_next (lfsr_next)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_row_s1 <= set_mem[set_in];
		end
		if (s1_move) begin
			set_mem[set_s1] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1    <= kind;
			set_s1     <= set_in;
			tag_s1     <= address[sacc_pkg::OFFSET_BITS + sacc_pkg::SET_BITS +: sacc_pkg::TAG_BITS];
			fwd_row_s1 <= new_row;
		end
		if (s1_move) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= sacc_pkg::POL_LRU;
			wt_mode_q   <= 1'b0;
			lfsr_q      <= sacc_pkg::LFSR_SEED;
			row_init_q  <= '0;
			s1_valid_q  <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sacc_pkg::CFG_POLICY:  policy_q  <= cfg_data;
					sacc_pkg::CFG_WT_MODE: wt_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_accept) begin
				s1_valid_q <= 1'b1;
				fwd_s1     <= s1_move && (set_in == set_s1);
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				row_init_q[set_s1] <= 1'b1;
				out_valid_q        <= 1'b1;
				if (lfsr_adv) begin
					lfsr_q <= lfsr_next;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = res_q.hit;
	assign way              = res_q.way;
	assign fill_needed      = res_q.fill_needed;
	assign writeback_needed = res_q.writeback_needed;
	assign writeback_line   = res_q.writeback_line;
	assign memory_write     = res_q.memory_write;

	`ASSERT_NEVER(a_stall_empty, in_stall && !s1_valid_q, "input stalled with empty lookup stage")
	`ASSERT_CLK(a_move_out, s1_move |=> out_valid, "item left lookup but no result shown")
	`ASSERT_CLK(a_wb_fill, out_valid && writeback_needed |-> fill_needed && !hit, "write-back without miss")
	`ASSERT_NEVER(a_lfsr_zero, lfsr_q == '0, "replacement LFSR locked at zero")

endmodule

// File: bench/tb_set_associative_cache_controller.sv
`timescale 1ns / 100ps

module tb_set_associative_cache_controller;
	import sacc_pkg::*;

	localparam bit KIND_READ  = 1'b0;
	localparam bit KIND_WRITE = 1'b1;
	localparam logic [CFG_DATA_BITS-1:0] POL_SPARE  = 2'd3;
	localparam logic [CFG_DATA_BITS-1:0] MODE_WBACK = 2'd0;
	localparam logic [CFG_DATA_BITS-1:0] MODE_WTHRU = 2'd1;
	localparam int NUM_PHASES  = 7;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 60;
	localparam int QUIET_LIMIT = 3000;

	// Directory predictor plus queue of expected results, in acceptance order
	class cache_dir_scoreboard;
		bit                   line_ok[SETS][WAYS];
		bit                   line_mod[SETS][WAYS];
		logic [TAG_BITS-1:0]  line_tg[SETS][WAYS];
		logic [WAY_BITS-1:0]  age_rank[SETS][WAYS];
		logic [WAY_BITS-1:0]  fifo_ptr[SETS];
		logic [LFSR_BITS-1:0] lfsr;
		logic [1:0]           policy;
		bit                   wt_mode;
		result_t              expected_q[$];
		int                   errors;

		function new();
			for (int s = 0; s < SETS; s++) begin
				fifo_ptr[s] = '0;
				for (int w = 0; w < WAYS; w++) begin
					line_ok[s][w]  = 1'b0;
					line_mod[s][w] = 1'b0;
					line_tg[s][w]  = '0;
					age_rank[s][w] = WAY_BITS'(w);
				end
			end
			lfsr    = 16'd1;
			policy  = POL_LRU;
			wt_mode = 1'b0;
			errors  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			if (idx == CFG_POLICY)
				policy = val[1:0];
			else if (idx == CFG_WT_MODE)
				wt_mode = val[0];
		endfunction

		function void note_access(bit is_wr, logic [ADDR_BITS-1:0] a);
			logic [LINE_BITS-1:0] ln;
			logic [TAG_BITS-1:0]  tg;
			logic [WAY_BITS-1:0]  old;
			int                   s;
			int                   w;
			bit                   found;
			result_t              r;
			ln = LINE_BITS'(a >> OFFSET_BITS);
			s  = int'(ln[SET_BITS-1:0]);
			tg = ln[LINE_BITS-1:SET_BITS];
			r  = '0;
			w  = 0;
			for (int k = 0; k < WAYS; k++) begin
				if (!r.hit && line_ok[s][k] && line_tg[s][k] == tg) begin
					r.hit = 1'b1;
					w = k;
				end
			end
			if (!r.hit) begin
				r.fill_needed = 1'b1;
				found = 1'b0;
				for (int k = 0; k < WAYS; k++) begin
					if (!found && !line_ok[s][k]) begin
						found = 1'b1;
						w = k;
					end
				end
				if (!found) begin
					case (policy)
						POL_LRU: begin
							for (int k = 0; k < WAYS; k++) begin
								if (!found && age_rank[s][k] == 0) begin
									found = 1'b1;
									w = k;
								end
							end
						end
						POL_FIFO: begin
							w = int'(fifo_ptr[s]) % WAYS;
							fifo_ptr[s] = WAY_BITS'((w + 1) % WAYS);
						end
						default: begin
							lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
							w = int'(lfsr) % WAYS;
						end
					endcase
					if (line_mod[s][w]) begin
						r.writeback_needed = 1'b1;
						r.writeback_line = WB_LINE_BITS'({line_tg[s][w], SET_BITS'(s)});
					end
				end
				line_ok[s][w]  = 1'b1;
				line_mod[s][w] = 1'b0;
				line_tg[s][w]  = tg;
			end
			old = age_rank[s][w];
			for (int k = 0; k < WAYS; k++) begin
				if (age_rank[s][k] > old)
					age_rank[s][k] = age_rank[s][k] - 1'b1;
			end
			age_rank[s][w] = WAY_BITS'(WAYS - 1);
			if (is_wr && !wt_mode)
				line_mod[s][w] = 1'b1;
			r.way = WAY_OUT_BITS'(w);
			r.memory_write = is_wr && wt_mode;
			expected_q.insert(expected_q.size(), r);
		endfunction

		task report_mismatch(string field, longint unsigned want, longint unsigned got);
			$display("%0t mismatch %s: expected %0h got %0h", $time, field, want, got);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 0, got);
			end else begin
				want = expected_q.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", want.hit, got.hit);
				if (got.way !== want.way)
					report_mismatch("way", want.way, got.way);
				if (got.fill_needed !== want.fill_needed)
					report_mismatch("fill_needed", want.fill_needed, got.fill_needed);
				if (got.writeback_needed !== want.writeback_needed)
					report_mismatch("writeback_needed", want.writeback_needed,
						got.writeback_needed);
				if (got.writeback_line !== want.writeback_line)
					report_mismatch("writeback_line", want.writeback_line, got.writeback_line);
				if (got.memory_write !== want.memory_write)
					report_mismatch("memory_write", want.memory_write, got.memory_write);
			end
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     kind = 1'b0;
	logic [ADDR_BITS-1:0]     address = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     hit;
	logic [WAY_OUT_BITS-1:0]  way;
	logic                     fill_needed;
	logic                     writeback_needed;
	logic [WB_LINE_BITS-1:0]  writeback_line;
	logic                     memory_write;

	cache_dir_scoreboard sb;
	bit                  idling_on = 1'b1;
	bit                  hold_req = 1'b0;
	int                  hold_left = 0;
	int                  stall_left = 0;
	int                  quiet_cycles = 0;
	logic [TAG_BITS-1:0] tag_pool[6];

	set_associative_cache_controller u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.address          (address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.way              (way),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_line   (writeback_line),
		.memory_write     (memory_write)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [ADDR_BITS-1:0] line_addr(logic [TAG_BITS-1:0] tg, int s, int off);
		return {tg, SET_BITS'(s), OFFSET_BITS'(off)};
	endfunction

	// Offer one item, hold it until taken; valid stays high for a following item
	task automatic send_item(bit is_wr, logic [ADDR_BITS-1:0] a);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= is_wr;
		address  <= a;
		do @(posedge clk); while (in_stall);
		sb.note_access(is_wr, a);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_random_item();
		int s;
		if ($urandom_range(0, 4) == 0) begin
			send_item(1'($urandom_range(0, 1)), $urandom);
		end else begin
			s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SETS - 1) : $urandom_range(0, 3);
			send_item(1'($urandom_range(0, 1)),
				line_addr(tag_pool[$urandom_range(0, 5)], s, $urandom_range(0, 7)));
		end
	endtask

	// Result side: check, then pick the next stall value
	always @(posedge clk) begin : result_side
		result_t seen;
		if (out_valid && !out_stall) begin
			seen.hit              = hit;
			seen.way              = way;
			seen.fill_needed      = fill_needed;
			seen.writeback_needed = writeback_needed;
			seen.writeback_line   = writeback_line;
			seen.memory_write     = memory_write;
			sb.check_result(seen);
		end
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left == 0 && stall_left == 0 && idling_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 11);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [1:0] phase_pol[NUM_PHASES];
		logic [1:0] phase_mode[NUM_PHASES];
		arst_n <= 1'b0;
		phase_pol  = '{POL_LRU, POL_FIFO, POL_RANDOM, POL_SPARE, POL_LRU, POL_FIFO, POL_RANDOM};
		phase_mode = '{MODE_WBACK, MODE_WBACK, MODE_WTHRU, MODE_WBACK, MODE_WTHRU, MODE_WTHRU,
			MODE_WBACK};
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(CFG_POLICY, phase_pol[p]);
			write_reg(CFG_WT_MODE, phase_mode[p]);
			for (int i = 0; i < 6; i++)
				tag_pool[i] = TAG_BITS'($urandom);
			if (p % 2 == 0) begin
				tag_pool[0] = '0;
				tag_pool[1] = '1;
			end
			idling_on = (p != NUM_PHASES - 1);
			if (p == 0) begin
				// fill a set, dirty it, then force evictions of dirty lines
				send_item(KIND_READ, line_addr(0, 0, 0));
				send_item(KIND_WRITE, line_addr(0, 0, 7));
				send_item(KIND_READ, line_addr(1, 0, 0));
				send_item(KIND_WRITE, line_addr(2, 0, 3));
				send_item(KIND_READ, line_addr(3, 0, 5));
				send_item(KIND_READ, line_addr('1, 0, 0));
				send_item(KIND_WRITE, 32'hFFFF_FFFF);
				send_item(KIND_READ, 32'hFFFF_FFF8);
				send_item(KIND_WRITE, line_addr(1, 0, 1));
				for (int t = 4; t < 9; t++)
					send_item(KIND_WRITE, line_addr(TAG_BITS'(t), 0, 2));
				for (int t = 0; t < 6; t++)
					send_item((t % 2) ? KIND_WRITE : KIND_READ,
						line_addr(TAG_BITS'(t + 10), 15, t));
			end
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_item();
		end

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/sacc_pkg.sv
hdl/sacc_lookup.sv
hdl/set_associative_cache_controller.sv
bench/tb_set_associative_cache_controller.sv
